>>> hdl/bdf2_pkg.sv
// Package for the direct form II biquad: widths, register indexes,
// microcode word layout and the control struct between sequencer and datapath.
// No dependencies.
package bdf2_pkg;

    localparam int COEF_W             = 18;
    localparam int NUM_COEFS          = 5;
    localparam int COEF_B0_RESET      = 16384;
    localparam int DEF_SAMPLE_WIDTH   = 16;
    localparam int DEF_STATE_WIDTH    = 24;
    localparam int DEF_COEF_FRAC_BITS = 14;
    localparam int APB_AW             = 5;
    localparam int APB_DW             = 32;
    localparam int NUM_STEPS          = 8;
    localparam int STEP_W             = 3;

    // Register indexes, also used to select the multiplier coefficient.
    typedef enum logic [2:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_idx;

    typedef enum logic [1:0] {
        DS_W1,
        DS_W2,
        DS_W
    } t_dsel;

    typedef enum logic [2:0] {
        OP_INIT_X,
        OP_LOAD_P,
        OP_ADD_P,
        OP_SUB_P,
        OP_ROUND_W,
        OP_ROUND_Y
    } t_acc_op;

    typedef enum logic [1:0] {
        WT_NONE,
        WT_IN,
        WT_OUT
    } t_wait;

    typedef struct packed {
        t_coef_idx          coef_sel;
        t_dsel              data_sel;
        t_acc_op            acc_op;
        t_wait              wait_on;
        logic [STEP_W-1:0]  next_step;
    } t_uop;

    typedef struct packed {
        t_coef_idx  coef_sel;
        t_dsel      data_sel;
        t_acc_op    acc_op;
        logic       fire;
    } t_dp_ctrl;

    typedef logic [NUM_COEFS-1:0][COEF_W-1:0] t_coef_bank;

endpackage

>>> hdl/bdf2_seq.sv
// Microcode sequencer for the biquad: step counter, program table and wait logic.
// Depends on bdf2_pkg.
module bdf2_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_free,
    output logic                o_in_ready,
    output logic                o_load_out,
    output bdf2_pkg::t_dp_ctrl  o_ctrl
);
    import bdf2_pkg::*;

    // Multiplier result lands one step after its operands are selected.
    localparam t_uop UCODE [NUM_STEPS] = '{
        '{COEF_A1, DS_W1, OP_INIT_X,  WT_IN,   STEP_W'(1)},
        '{COEF_A2, DS_W2, OP_SUB_P,   WT_NONE, STEP_W'(2)},
        '{COEF_B1, DS_W1, OP_SUB_P,   WT_NONE, STEP_W'(3)},
        '{COEF_B1, DS_W1, OP_ROUND_W, WT_NONE, STEP_W'(4)},
        '{COEF_B2, DS_W2, OP_LOAD_P,  WT_NONE, STEP_W'(5)},
        '{COEF_B0, DS_W,  OP_ADD_P,   WT_NONE, STEP_W'(6)},
        '{COEF_B0, DS_W,  OP_ADD_P,   WT_NONE, STEP_W'(7)},
        '{COEF_B0, DS_W,  OP_ROUND_Y, WT_OUT,  STEP_W'(0)}
    };

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uop              uop;
    logic              fire;

    always_comb begin
        uop = UCODE[r_step];
        unique case (uop.wait_on)
            WT_NONE: fire = 1'b1;
            WT_IN:   fire = i_in_valid;
            WT_OUT:  fire = i_out_free;
            default: fire = 1'b0;
        endcase
        // hold the step until its wait condition clears
        n_step = fire ? uop.next_step : r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_in_ready      = (uop.wait_on == WT_IN);
    assign o_load_out      = fire && (uop.acc_op == OP_ROUND_Y);
    assign o_ctrl.coef_sel = uop.coef_sel;
    assign o_ctrl.data_sel = uop.data_sel;
    assign o_ctrl.acc_op   = uop.acc_op;
    assign o_ctrl.fire     = fire;

endmodule

>>> hdl/bdf2_dp.sv
// Biquad datapath: shared coefficient multiplier, accumulator, round and
// saturate, and the two delay registers. Depends on bdf2_pkg.
module bdf2_dp #(
    parameter int SAMPLE_WIDTH   = bdf2_pkg::DEF_SAMPLE_WIDTH,
    parameter int STATE_WIDTH    = bdf2_pkg::DEF_STATE_WIDTH,
    parameter int COEF_FRAC_BITS = bdf2_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bdf2_pkg::t_dp_ctrl             i_ctrl,
    input  bdf2_pkg::t_coef_bank           i_coefs,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic signed [SAMPLE_WIDTH-1:0] o_y,
    output logic                           o_clip
);
    import bdf2_pkg::*;

    localparam int PROD_W = COEF_W + STATE_WIDTH;
    localparam int X_W    = SAMPLE_WIDTH + COEF_FRAC_BITS;
    localparam int WF_W   = STATE_WIDTH + COEF_FRAC_BITS;
    localparam int MAX_A  = (PROD_W > X_W) ? PROD_W : X_W;
    localparam int MAX_B  = (MAX_A > WF_W) ? MAX_A : WF_W;
    localparam int ACC_W  = MAX_B + 2;
    localparam int RND_W  = ACC_W - COEF_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [RND_W-1:0] W_MAX =
        {{(RND_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [RND_W-1:0] W_MIN = ~W_MAX;
    localparam logic signed [RND_W-1:0] Y_MAX =
        {{(RND_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [RND_W-1:0] Y_MIN = ~Y_MAX;

    logic signed [COEF_W-1:0]      mul_a;
    logic signed [STATE_WIDTH-1:0] mul_b;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       x_ext;
    logic signed [ACC_W-1:0]       acc_half;
    logic signed [RND_W-1:0]       rnd;
    logic signed [STATE_WIDTH-1:0] r_w;
    logic signed [STATE_WIDTH-1:0] r_w1;
    logic signed [STATE_WIDTH-1:0] r_w2;
    logic signed [STATE_WIDTH-1:0] w_sat;
    logic                          r_clip_w;
    logic                          w_hi;
    logic                          w_lo;
    logic                          y_hi;
    logic                          y_lo;

    always_comb begin
        mul_a = i_coefs[i_ctrl.coef_sel];
        case (i_ctrl.data_sel)
            DS_W1:   mul_b = r_w1;
            DS_W2:   mul_b = r_w2;
            DS_W:    mul_b = r_w;
            default: mul_b = r_w;
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign x_ext    = {{(ACC_W-X_W){i_sample_in[SAMPLE_WIDTH-1]}}, i_sample_in,
                       {COEF_FRAC_BITS{1'b0}}};

    // round half up: add half an LSB, keep the high part (floor)
    assign acc_half = r_acc + HALF;
    assign rnd      = acc_half[ACC_W-1:COEF_FRAC_BITS];

    assign w_hi  = (rnd > W_MAX);
    assign w_lo  = (rnd < W_MIN);
    assign w_sat = w_hi ? W_MAX[STATE_WIDTH-1:0] :
                   w_lo ? W_MIN[STATE_WIDTH-1:0] : rnd[STATE_WIDTH-1:0];

    assign y_hi  = (rnd > Y_MAX);
    assign y_lo  = (rnd < Y_MIN);
    assign o_y   = y_hi ? Y_MAX[SAMPLE_WIDTH-1:0] :
                   y_lo ? Y_MIN[SAMPLE_WIDTH-1:0] : rnd[SAMPLE_WIDTH-1:0];
    assign o_clip = r_clip_w | y_hi | y_lo;

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        if (i_ctrl.fire) begin
            case (i_ctrl.acc_op)
                OP_INIT_X:  r_acc <= x_ext;
                OP_LOAD_P:  r_acc <= prod_ext;
                OP_ADD_P:   r_acc <= r_acc + prod_ext;
                OP_SUB_P:   r_acc <= r_acc - prod_ext;
                OP_ROUND_W: begin
                    r_w      <= w_sat;
                    r_clip_w <= w_hi | w_lo;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1 <= '0;
            r_w2 <= '0;
        end else if (i_ctrl.fire && (i_ctrl.acc_op == OP_ROUND_Y)) begin
            // advance the delay line
            r_w2 <= r_w1;
            r_w1 <= r_w;
        end
    end

endmodule

>>> hdl/biquad_direct_form_two_unit.sv
// o_out_valid is registered and rises after the last step fires while the
// output register is free; a held result stalls the last step until it is taken.
// The eight-step microprogram runs all five products through one shared
// multiplier, and it takes a new sample only once it is back at its first step.
// A finished result waits in the output register while the next sample runs.
// Reset (synchronous, active low) clears both delays, the step counter and the
// output valid flag, and loads b0 = 1.0 (at the default 14 fraction bits), others zero.
module biquad_direct_form_two_unit #(
    parameter int SAMPLE_WIDTH   = bdf2_pkg::DEF_SAMPLE_WIDTH,
    parameter int STATE_WIDTH    = bdf2_pkg::DEF_STATE_WIDTH,
    parameter int COEF_FRAC_BITS = bdf2_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_clipped,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bdf2_pkg::APB_AW-1:0]    paddr,
    input  logic [bdf2_pkg::APB_DW-1:0]    pwdata,
    output logic [bdf2_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import bdf2_pkg::*;

    t_coef_bank                     r_coefs;
    t_coef_idx                      reg_idx;
    logic                           idx_ok;
    logic                           cfg_wr;
    t_dp_ctrl                       ctrl;
    logic                           load_out;
    logic                           out_free;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample_out;
    logic                           r_clipped;
    logic signed [SAMPLE_WIDTH-1:0] y;
    logic                           clip;

    assign reg_idx = t_coef_idx'(paddr[APB_AW-1:2]);
    assign idx_ok  = (32'(paddr[APB_AW-1:2]) < NUM_COEFS);
    assign cfg_wr  = psel && penable && pwrite && idx_ok;
    assign pready  = 1'b1;

    always_comb begin
        if (idx_ok) begin
            prdata = {{(APB_DW-COEF_W){r_coefs[reg_idx][COEF_W-1]}}, r_coefs[reg_idx]};
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // b0 sits in the lowest slot of the bank
            r_coefs <= {{((NUM_COEFS-1)*COEF_W){1'b0}}, COEF_W'(COEF_B0_RESET)};
        end else if (cfg_wr) begin
            r_coefs[reg_idx] <= pwdata[COEF_W-1:0];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    bdf2_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .o_in_ready (o_in_ready),
        .o_load_out (load_out),
        .o_ctrl     (ctrl)
    );

    bdf2_dp #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .STATE_WIDTH    (STATE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_coefs     (r_coefs),
        .i_sample_in (i_sample_in),
        .o_y         (y),
        .o_clip      (clip)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_sample_out <= y;
            r_clipped    <= clip;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

endmodule

>>> hdl/bdf2_chk.sv
// Port-level checks for the biquad top level, bound to it below.
// Depends on biquad_direct_form_two_unit.
module bdf2_chk #(
    parameter int SAMPLE_WIDTH = bdf2_pkg::DEF_SAMPLE_WIDTH
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [SAMPLE_WIDTH-1:0] o_sample_out,
    input logic                    o_clipped
);

    // reset leaves the block idle with nothing to deliver
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after reset");

    // after a taken request o_in_ready stays low while the program steps on, so the next request waits
    a_min_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready ##1 !o_in_ready ##1 !o_in_ready
            ##1 !o_in_ready ##1 !o_in_ready ##1 !o_in_ready)
        else $error("request taken before the previous one finished");

    // a new result only appears at the end of a running sample
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a sample in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_sample_out) && $stable(o_clipped)))
        else $error("stalled result changed or dropped");

endmodule

bind biquad_direct_form_two_unit bdf2_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bdf2_chk (.*);
